### hdl/dlct_pkg.sv
`default_nettype none

package dlct_pkg;

    localparam int CNT_W  = 17;
    localparam int HOLD_W = 4;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0]  ON_TICKS_RST   = CNT_W'(1);
    localparam logic [CNT_W-1:0]  OFF_TICKS_RST  = CNT_W'(1);
    localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = HOLD_W'(3);
    // largest usable hold; the all-ones code is treated as this
    localparam logic [HOLD_W-1:0] HOLD_MAX       = HOLD_W'(14);

    typedef enum logic [1:0] {
        REG_ON_TICKS   = 2'd0,
        REG_OFF_TICKS  = 2'd1,
        REG_HOLD_TICKS = 2'd2,
        REG_NONE       = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0]  on_ticks;
        logic [CNT_W-1:0]  off_ticks;
        logic [HOLD_W-1:0] hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic              power_on;
        logic              light_state;
        logic [HOLD_W-1:0] press_count;
        logic [CNT_W-1:0]  on_left;
        logic [CNT_W-1:0]  off_left;
    } status_t;

endpackage

`default_nettype wire

### hdl/dlct_regs.sv
`default_nettype none

module dlct_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dlct_pkg::ADDR_W-1:0] paddr,
    input  wire logic [dlct_pkg::DATA_W-1:0] pwdata,
    output logic      [dlct_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output dlct_pkg::cfg_t                   cfg
);
    import dlct_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_ON_TICKS:   cfg_next.on_ticks   = pwdata[CNT_W-1:0];
                REG_OFF_TICKS:  cfg_next.off_ticks  = pwdata[CNT_W-1:0];
                REG_HOLD_TICKS: cfg_next.hold_ticks = pwdata[HOLD_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_ticks   <= ON_TICKS_RST;
            cfg_reg.off_ticks  <= OFF_TICKS_RST;
            cfg_reg.hold_ticks <= HOLD_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_ON_TICKS:   prdata = DATA_W'(cfg_reg.on_ticks);
            REG_OFF_TICKS:  prdata = DATA_W'(cfg_reg.off_ticks);
            REG_HOLD_TICKS: prdata = DATA_W'(cfg_reg.hold_ticks);
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hdl/dlct_core.sv
`default_nettype none

module dlct_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire dlct_pkg::cfg_t cfg,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           s_button_held,
    input  wire logic           s_is_dark,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic                m_power_lamp,
    output logic                m_light_active,
    output dlct_pkg::status_t   status
);
    import dlct_pkg::*;

    // input stage
    logic    in_valid_reg;
    logic    in_held_reg;
    logic    in_dark_reg;
    // result stage
    logic    out_valid_reg;
    logic    out_lamp_reg;
    logic    out_light_reg;
    // tick state
    status_t st_reg;
    status_t st_next;

    logic              advance;
    logic [HOLD_W-1:0] hold;

    // input stage moves on whenever the result slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign hold    = (cfg.hold_ticks > HOLD_MAX) ? HOLD_MAX : cfg.hold_ticks;

    always_comb begin
        st_next = st_reg;

        // phase countdown
        if (st_reg.power_on) begin
            if (st_reg.on_left != '0) begin
                st_next.light_state = 1'b1;
                st_next.on_left     = st_reg.on_left - CNT_W'(1);
            end else if (st_reg.off_left != '0) begin
                st_next.light_state = 1'b0;
                st_next.off_left    = st_reg.off_left - CNT_W'(1);
            end else begin
                st_next.on_left  = cfg.on_ticks;
                st_next.off_left = cfg.off_ticks;
            end
        end

        // button hold, one toggle per press
        if (in_held_reg) begin
            if (st_reg.press_count < hold) begin
                st_next.press_count = st_reg.press_count + HOLD_W'(1);
            end else if (st_reg.press_count == hold) begin
                if (!st_reg.power_on) begin
                    st_next.power_on = 1'b1;
                    st_next.on_left  = cfg.on_ticks;
                    st_next.off_left = cfg.off_ticks;
                end else begin
                    st_next.power_on    = 1'b0;
                    st_next.light_state = 1'b0;
                    st_next.on_left     = '0;
                    st_next.off_left    = '0;
                end
                st_next.press_count = st_reg.press_count + HOLD_W'(1);
            end
        end else begin
            st_next.press_count = '0;
        end

        // light sensor
        if (in_dark_reg) begin
            if (st_next.power_on) begin
                st_next.light_state = (st_next.on_left != '0);
            end
        end else begin
            st_next.light_state = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_held_reg <= s_button_held;
            in_dark_reg <= s_is_dark;
        end
        if (advance) begin
            out_lamp_reg  <= st_reg.power_on;
            out_light_reg <= st_next.light_state;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_power_lamp   = out_lamp_reg;
    assign m_light_active = out_light_reg;
    assign status         = st_reg;

endmodule

`default_nettype wire

### hdl/dusk_light_cycle_timer.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_button_held, s_is_dark
// m_        out        m_valid / m_ready    m_power_lamp, m_light_active
// apb       in         psel/penable/pready  paddr, pwdata, pwrite -> prdata
//
// Input register, then result register; one request per cycle while m_ready is high.
// The tick update is one combinational step between the input and result registers.
// Reset (aresetn low, synchronous) clears valids and tick state, loads register defaults.
// A stalled result holds its register; the input side keeps accepting as long as
// the input register can move into the result slot in the same cycle.
`default_nettype none

module dusk_light_cycle_timer (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dlct_pkg::ADDR_W-1:0] paddr,
    input  wire logic [dlct_pkg::DATA_W-1:0] pwdata,
    output logic      [dlct_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_button_held,
    input  wire logic                        s_is_dark,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_power_lamp,
    output logic                             m_light_active
);
    import dlct_pkg::*;

    cfg_t    cfg;
    status_t status;

    dlct_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dlct_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button_held  (s_button_held),
        .s_is_dark      (s_is_dark),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_power_lamp   (m_power_lamp),
        .m_light_active (m_light_active),
        .status         (status)
    );

    // the light can only be lit while powered
    a_light_needs_power: assert property (@(posedge aclk) disable iff (!aresetn)
        !status.power_on |-> !status.light_state)
        else $error("light active while unpowered");

    // power-off clears both countdowns
    a_off_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(status.power_on) |-> (status.on_left == '0) && (status.off_left == '0))
        else $error("countdowns not cleared at power-off");

    // power-on loads the on phase length
    a_on_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(status.power_on) |-> status.on_left == cfg.on_ticks)
        else $error("on countdown not loaded at power-on");

endmodule

`default_nettype wire

### verif/dusk_light_cycle_timer_tb.sv
module dusk_light_cycle_timer_tb;

    import dlct_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic held;
        logic dark;
    } tick_t;

    typedef struct packed {
        logic power_lamp;
        logic light_active;
    } lamp_view_t;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic                s_button_held;
    logic                s_is_dark;
    logic                m_valid;
    logic                m_ready;
    logic                m_power_lamp;
    logic                m_light_active;

    tick_t      tick_q[$];
    lamp_view_t due_views[$];
    cfg_t       lamp_cfg;
    status_t    lamp_st;
    logic       in_taken;
    logic       calm;
    int         cyc;
    int         quiet;
    int         errors;

    dusk_light_cycle_timer u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button_held  (s_button_held),
        .s_is_dark      (s_is_dark),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_power_lamp   (m_power_lamp),
        .m_light_active (m_light_active)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // window with no idling on either side
    assign calm = (cyc >= 1500) && (cyc < 2100);

    // one tick of the lamp timer; updates the private state copy
    function automatic lamp_view_t step_lamp(input logic held, input logic dark);
        lamp_view_t        v;
        logic [HOLD_W-1:0] hold;
        hold = (lamp_cfg.hold_ticks > HOLD_MAX) ? HOLD_MAX : lamp_cfg.hold_ticks;
        v.power_lamp = lamp_st.power_on;

        if (lamp_st.power_on) begin
            if (lamp_st.on_left != '0) begin
                lamp_st.light_state = 1'b1;
                lamp_st.on_left = lamp_st.on_left - CNT_W'(1);
            end else if (lamp_st.off_left != '0) begin
                lamp_st.light_state = 1'b0;
                lamp_st.off_left = lamp_st.off_left - CNT_W'(1);
            end else begin
                lamp_st.on_left = lamp_cfg.on_ticks;
                lamp_st.off_left = lamp_cfg.off_ticks;
            end
        end

        if (held) begin
            if (lamp_st.press_count < hold) begin
                lamp_st.press_count = lamp_st.press_count + HOLD_W'(1);
            end else if (lamp_st.press_count == hold) begin
                if (!lamp_st.power_on) begin
                    lamp_st.power_on = 1'b1;
                    lamp_st.on_left = lamp_cfg.on_ticks;
                    lamp_st.off_left = lamp_cfg.off_ticks;
                end else begin
                    lamp_st.power_on = 1'b0;
                    lamp_st.light_state = 1'b0;
                    lamp_st.on_left = '0;
                    lamp_st.off_left = '0;
                end
                lamp_st.press_count = lamp_st.press_count + HOLD_W'(1);
            end
        end else begin
            lamp_st.press_count = '0;
        end

        if (dark) begin
            if (lamp_st.power_on) begin
                lamp_st.light_state = (lamp_st.on_left != '0);
            end
        end else begin
            lamp_st.light_state = 1'b0;
        end

        v.light_active = lamp_st.light_state;
        return v;
    endfunction

    // request driver and ready generator
    always @(negedge aclk) begin
        tick_t t;
        if (!s_valid || in_taken) begin
            if ((tick_q.size() != 0) && (calm || ($urandom_range(0, 99) >= 33))) begin
                t = tick_q.pop_front();
                s_button_held <= t.held;
                s_is_dark <= t.dark;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
            in_taken <= 1'b0;
        end
        m_ready <= calm || ($urandom_range(0, 99) >= 33);
    end

    // predictor, result checker and watchdog
    always @(posedge aclk) begin
        lamp_view_t want;
        cyc <= cyc + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                due_views.push_back(step_lamp(s_button_held, s_is_dark));
                in_taken <= 1'b1;
            end
            if (m_valid && m_ready) begin
                if (due_views.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual lamp %0b light %0b",
                             $time, m_power_lamp, m_light_active);
                    errors++;
                end else begin
                    want = due_views.pop_front();
                    if (m_power_lamp !== want.power_lamp) begin
                        $display("%0t: power_lamp mismatch: expected %0b actual %0b",
                                 $time, want.power_lamp, m_power_lamp);
                        errors++;
                    end
                    if (m_light_active !== want.light_active) begin
                        $display("%0t: light_active mismatch: expected %0b actual %0b",
                                 $time, want.light_active, m_light_active);
                        errors++;
                    end
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, due_views.size());
            $display("FAILURE");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic push_tick(input logic held, input logic dark);
        tick_t t;
        t.held = held;
        t.dark = dark;
        tick_q.push_back(t);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_ON_TICKS:   lamp_cfg.on_ticks = data[CNT_W-1:0];
            REG_OFF_TICKS:  lamp_cfg.off_ticks = data[CNT_W-1:0];
            REG_HOLD_TICKS: lamp_cfg.hold_ticks = data[HOLD_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // wait until every request has been answered, then let the pipe drain
    task automatic drain;
        while ((tick_q.size() != 0) || s_valid || (due_views.size() != 0))
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // mostly full presses (long enough to toggle) with release gaps; some noise
    task automatic gen_ticks(input int count);
        int   made;
        int   len;
        int   hold_eff;
        logic dark;
        made = 0;
        dark = 1'($urandom_range(0, 1));
        while (made < count) begin
            if ($urandom_range(0, 99) < 15) begin
                push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                made++;
            end else begin
                hold_eff = (lamp_cfg.hold_ticks > HOLD_MAX) ? int'(HOLD_MAX)
                                                            : int'(lamp_cfg.hold_ticks);
                len = hold_eff + $urandom_range(1, 3);
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(1, hold_eff + 1);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 5) == 0) dark = !dark;
                    push_tick(1'b1, dark);
                    made++;
                end
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 5) == 0) dark = !dark;
                    push_tick(1'b0, dark);
                    made++;
                end
            end
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_button_held = 1'b0;
        s_is_dark = 1'b0;
        m_ready = 1'b0;
        in_taken = 1'b0;
        cyc = 0;
        quiet = 0;
        errors = 0;
        lamp_cfg.on_ticks = ON_TICKS_RST;
        lamp_cfg.off_ticks = OFF_TICKS_RST;
        lamp_cfg.hold_ticks = HOLD_TICKS_RST;
        lamp_st = '0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: power on by a long press, dark/light, power off
        for (int i = 0; i < 5; i++) push_tick(1'b1, 1'b1);
        for (int i = 0; i < 4; i++) push_tick(1'b0, 1'b1);
        for (int i = 0; i < 2; i++) push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        for (int i = 0; i < 5; i++) push_tick(1'b1, 1'b0);
        for (int i = 0; i < 2; i++) push_tick(1'b0, 1'b1);
        gen_ticks(150);
        drain();

        for (int p = 1; p <= 8; p++) begin
            case (p)
                1: begin
                    // zero phases, zero hold; upper bits must be dropped
                    apb_write(REG_ON_TICKS, 32'hFFFE_0000);
                    apb_write(REG_OFF_TICKS, 32'h0000_0000);
                    apb_write(REG_HOLD_TICKS, 32'hFFFF_FFF0);
                end
                2: begin
                    // longest phases, out-of-range hold acts as the maximum
                    apb_write(REG_ON_TICKS, 32'hFFFF_FFFF);
                    apb_write(REG_OFF_TICKS, 32'h0001_FFFF);
                    apb_write(REG_HOLD_TICKS, 32'hFFFF_FFFF);
                    apb_write(REG_NONE, 32'h0000_0000);
                end
                3: begin
                    apb_write(REG_ON_TICKS, 32'd3);
                    apb_write(REG_OFF_TICKS, 32'd2);
                    apb_write(REG_HOLD_TICKS, 32'd1);
                end
                4: begin
                    apb_write(REG_ON_TICKS, 32'd0);
                    apb_write(REG_OFF_TICKS, 32'd5);
                    apb_write(REG_HOLD_TICKS, 32'd2);
                end
                5: begin
                    apb_write(REG_ON_TICKS, 32'd7);
                    apb_write(REG_OFF_TICKS, 32'd0);
                    apb_write(REG_HOLD_TICKS, 32'd14);
                end
                default: begin
                    apb_write(REG_ON_TICKS, $urandom_range(0, 12));
                    apb_write(REG_OFF_TICKS, $urandom_range(0, 12));
                    apb_write(REG_HOLD_TICKS, $urandom_range(0, 15));
                end
            endcase
            gen_ticks(160);
            drain();
        end

        repeat (6) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
hdl/dlct_pkg.sv
hdl/dlct_regs.sv
hdl/dlct_core.sv
hdl/dusk_light_cycle_timer.sv
verif/dusk_light_cycle_timer_tb.sv
